### rtl/core/blpg_pkg.sv
// Shared types and constants for the Bresenham line pixel generator.
`timescale 1ns / 1ps

package blpg_pkg;

  localparam int COORD_W     = 12;
  localparam int ERR_W       = 14;
  localparam int ROW_W       = 16;
  localparam int ADDR_W      = 32;
  localparam int COLOR_W     = 8;
  localparam int PROD_W      = COORD_W + ROW_W;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRAW_COLOR   = 2'd0,
    CFG_ROW_BYTES    = 2'd1,
    CFG_BASE_ADDRESS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic   op;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } in_item_t;

  typedef struct packed {
    logic              pixel_valid;
    logic [ADDR_W-1:0] pixel_address;
    logic [COLOR_W-1:0] pixel_value;
    logic              last_pixel;
  } out_item_t;

  // Classified command handed from front to back through the queue.
  typedef struct packed {
    op_e_t  kind;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    logic   x_neg;
    coord_t span_x;
    coord_t span_y;
  } cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] draw_color;
    logic [ROW_W-1:0]   row_bytes;
    logic [ADDR_W-1:0]  base_address;
  } cfg_t;

endpackage

### rtl/core/bresenham_line_pixel_gen.sv
// Top level of the Bresenham line pixel generator.
//
// Channels: cmd (valid/ready) takes start and step items, pix (valid/ready)
// returns exactly one result per item, cfg (valid/ready) writes draw_color,
// row_bytes and base_address; cfg_ready is always high, unknown indexes are
// dropped. The user must write config only while no line item is in flight;
// the block does not enforce it. A start transaction loads the endpoints
// and yields the first pixel; each step on an active line yields the next
// pixel's address and color. Throughput: one item per cycle while pix_ready
// is high; the stepping update is combinational. An accepted item is written
// into the queue, then passes the step stage, the row multiply stage and the
// address add / output register before its result shows.
// Reset (synchronous, rst high) clears the queue, the pipeline, the line
// state and the registers; drawing stays disabled until base_address and
// row_bytes are nonzero.
// When the receiver stalls, the output register holds; the pipeline and the
// queue fill up and cmd_ready drops once the queue is full.
`timescale 1ns / 1ps

module bresenham_line_pixel_gen import blpg_pkg::*; #(
  parameter int COORD_MAX = 4095,
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  in_item_t             cmd,
  output logic                 pix_valid,
  input  logic                 pix_ready,
  output out_item_t            pix,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DRAW_COLOR:   cfg.draw_color   <= cfg_data[COLOR_W-1:0];
        CFG_ROW_BYTES:    cfg.row_bytes    <= cfg_data[ROW_W-1:0];
        CFG_BASE_ADDRESS: cfg.base_address <= cfg_data;
        default: ;
      endcase
    end
  end

  blpg_front #(
    .COORD_MAX(COORD_MAX)
  ) u_front (
    .item(cmd),
    .cmd (front_cmd)
  );

  blpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(cmd_valid),
    .push_ready(cmd_ready),
    .push_data (front_cmd),
    .pop_valid (back_valid),
    .pop_ready (back_ready),
    .pop_data  (back_cmd)
  );

  blpg_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(back_valid),
    .cmd_ready(back_ready),
    .cmd      (back_cmd),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix)
  );

endmodule

### rtl/core/blpg_front.sv
// Front end: clamps endpoints, orders them top to bottom and derives spans.
`timescale 1ns / 1ps

module blpg_front import blpg_pkg::*; #(
  parameter int COORD_MAX = 4095
) (
  input  in_item_t item,
  output cmd_t     cmd
);

  function automatic coord_t clamp(input coord_t v);
    coord_t r;
    if (17'(v) > 17'(COORD_MAX)) r = COORD_W'(COORD_MAX);
    else r = v;
    return r;
  endfunction

  coord_t xa, ya, xb, yb;
  coord_t x0, y0, x1, y1;
  logic   swap;

  always_comb begin
    xa = clamp(item.x_start);
    ya = clamp(item.y_start);
    xb = clamp(item.x_end);
    yb = clamp(item.y_end);
    swap = ya > yb;
    x0 = swap ? xb : xa;
    y0 = swap ? yb : ya;
    x1 = swap ? xa : xb;
    y1 = swap ? ya : yb;

    cmd.kind   = item.op ? OP_STEP : OP_START;
    cmd.x0     = x0;
    cmd.y0     = y0;
    cmd.x1     = x1;
    cmd.y1     = y1;
    cmd.x_neg  = x1 < x0;
    cmd.span_x = (x1 < x0) ? (x0 - x1) : (x1 - x0);
    cmd.span_y = y1 - y0;
  end

endmodule

### rtl/core/blpg_queue.sv
// Short command queue between front and back.
`timescale 1ns / 1ps

module blpg_queue import blpg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

### rtl/core/blpg_back.sv
// Back end: Bresenham stepping, row multiply and address add, output register.
`timescale 1ns / 1ps

module blpg_back import blpg_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      pix_valid,
  input  logic      pix_ready,
  output out_item_t pix
);

  localparam int ADDR_KEEP = (ADDR_BITS > ADDR_W) ? ADDR_W : ADDR_BITS;
  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << ADDR_KEEP) - 64'd1);

  // line state
  coord_t                 cur_x, cur_y, stop_x, stop_y, span_x, span_y;
  logic                   x_dir_neg;
  logic signed [ERR_W-1:0] err_term;
  logic                   line_active;

  coord_t                 cur_x_next, cur_y_next, stop_x_next, stop_y_next;
  coord_t                 span_x_next, span_y_next;
  logic                   x_dir_neg_next;
  logic signed [ERR_W-1:0] err_term_next;
  logic                   line_active_next;
  logic                   res_pix, res_last;

  // stage registers
  logic        e_valid, e_pix, e_last;
  coord_t      e_x, e_y;
  logic        m_valid, m_pix, m_last;
  coord_t      m_x;
  logic [PROD_W-1:0] m_prod;

  logic adv_o, adv_m, adv_e, take;
  logic enabled;
  logic signed [ERR_W:0] twice;
  logic signed [ERR_W:0] neg_sy;
  logic signed [ERR_W:0] pos_sx;
  logic [ADDR_W-1:0] addr_sum;

  assign enabled   = (cfg.base_address != '0) && (cfg.row_bytes != '0);
  assign adv_o     = !pix_valid || pix_ready;
  assign adv_m     = !m_valid || adv_o;
  assign adv_e     = !e_valid || adv_m;
  assign cmd_ready = adv_e;
  assign take      = cmd_valid && adv_e;

  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    stop_x_next      = stop_x;
    stop_y_next      = stop_y;
    span_x_next      = span_x;
    span_y_next      = span_y;
    x_dir_neg_next   = x_dir_neg;
    err_term_next    = err_term;
    line_active_next = line_active;
    res_pix          = 1'b0;
    res_last         = 1'b0;
    twice  = {err_term, 1'b0};
    neg_sy = -$signed({3'b000, span_y});
    pos_sx = $signed({3'b000, span_x});

    unique case (cmd.kind)
      OP_START: begin
        line_active_next = 1'b0;
        if (enabled) begin
          cur_x_next     = cmd.x0;
          cur_y_next     = cmd.y0;
          stop_x_next    = cmd.x1;
          stop_y_next    = cmd.y1;
          x_dir_neg_next = cmd.x_neg;
          span_x_next    = cmd.span_x;
          span_y_next    = cmd.span_y;
          err_term_next  = $signed({2'b00, cmd.span_x}) - $signed({2'b00, cmd.span_y});
          res_last       = (cmd.x0 == cmd.x1) && (cmd.y0 == cmd.y1);
          res_pix        = 1'b1;
          line_active_next = !res_last;
        end
      end
      OP_STEP: begin
        if (line_active && enabled) begin
          if (twice > neg_sy) begin
            cur_x_next = x_dir_neg ? cur_x - 1'b1 : cur_x + 1'b1;
          end
          if (twice < pos_sx) begin
            cur_y_next = cur_y + 1'b1;
          end
          // both corrections are based on the error term before this step
          err_term_next = err_term
                        - ((twice > neg_sy) ? $signed({2'b00, span_y}) : '0)
                        + ((twice < pos_sx) ? $signed({2'b00, span_x}) : '0);
          res_last = (cur_x_next == stop_x) && (cur_y_next == stop_y);
          res_pix  = 1'b1;
          if (res_last) line_active_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      stop_x      <= '0;
      stop_y      <= '0;
      span_x      <= '0;
      span_y      <= '0;
      x_dir_neg   <= 1'b0;
      err_term    <= '0;
      line_active <= 1'b0;
    end else if (take) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      stop_x      <= stop_x_next;
      stop_y      <= stop_y_next;
      span_x      <= span_x_next;
      span_y      <= span_y_next;
      x_dir_neg   <= x_dir_neg_next;
      err_term    <= err_term_next;
      line_active <= line_active_next;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      m_valid   <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (adv_e) e_valid   <= cmd_valid;
      if (adv_m) m_valid   <= e_valid;
      if (adv_o) pix_valid <= m_valid;
    end
  end

  assign addr_sum = cfg.base_address + ADDR_W'(m_prod) + ADDR_W'(m_x);

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      e_pix  <= res_pix;
      e_last <= res_last;
      e_x    <= cur_x_next;
      e_y    <= cur_y_next;
    end
    if (adv_m && e_valid) begin
      m_pix  <= e_pix;
      m_last <= e_last;
      m_x    <= e_x;
      m_prod <= e_y * cfg.row_bytes;
    end
    if (adv_o && m_valid) begin
      if (m_pix) begin
        pix.pixel_valid   <= 1'b1;
        pix.pixel_address <= addr_sum & ADDR_MASK;
        pix.pixel_value   <= cfg.draw_color;
        pix.last_pixel    <= m_last;
      end else begin
        pix <= '0;
      end
    end
  end

endmodule
